### rtl/mca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mca_pkg;
   localparam int DEF_MAX_ROWS    = 16;
   localparam int DEF_MAX_COLUMNS = 16;
   localparam int DEF_COST_BITS   = 16;
   localparam int COUNT_BITS      = 5;
   localparam int FIELD_BITS      = 4;
   localparam int DUAL_BITS       = 40;

   localparam logic [0:0] CSR_ROW_COUNT    = 1'b0;
   localparam logic [0:0] CSR_COLUMN_COUNT = 1'b1;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_CHECK,
      ST_INIT,
      ST_PHASE,
      ST_MIN_REQ,
      ST_MIN_ACC,
      ST_UPDATE,
      ST_ZERO_REQ,
      ST_ZERO_ACC,
      ST_PICK,
      ST_AUG,
      ST_RELAX_REQ,
      ST_RELAX_BEST,
      ST_RELAX_ACC,
      ST_EMIT,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic clear_all;
      logic phase_start;
      logic min_clear;
      logic min_issue;
      logic min_acc;
      logic apply_delta;
      logic zero_clear;
      logic zero_issue;
      logic zero_acc;
      logic pick;
      logic aug_step;
      logic best_issue;
      logic best_capture;
      logic relax_issue;
      logic relax_acc;
   } cmd_type;

   typedef struct packed {
      logic have_right;
      logic right_free;
      logic aug_done;
   } status_type;
endpackage
`default_nettype wire

### rtl/mca_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mca_req_if #(parameter int COST_BITS = 16);
   logic valid;
   logic ready;
   logic signed [COST_BITS-1:0] cost;
   modport source (output valid, output cost, input ready);
   modport sink (input valid, input cost, output ready);
endinterface

interface mca_rsp_if;
   logic valid;
   logic ready;
   logic [3:0] row;
   logic [3:0] column;
   logic last;
   logic error;
   modport source (output valid, output row, output column, output last, output error,
                   input ready);
   modport sink (input valid, input row, input column, input last, input error,
                 output ready);
endinterface
`default_nettype wire

### rtl/mca_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/mca_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module mca_datapath #(
   parameter int MAX_ROWS    = 16,
   parameter int MAX_COLUMNS = 16,
   parameter int COST_BITS   = 16
) (
   input  wire logic                        clock,
   input  wire mca_pkg::cmd_type            cmd,
   input  wire logic [$clog2(MAX_ROWS)-1:0]    row_idx,
   input  wire logic [$clog2(MAX_COLUMNS)-1:0] col_idx,
   input  wire logic [$clog2(MAX_ROWS)-1:0]    start_row,
   input  wire logic [$clog2(MAX_ROWS)-1:0]    n_last,
   input  wire logic [$clog2(MAX_COLUMNS)-1:0] m_last,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(MAX_ROWS)-1:0]    wr_row,
   input  wire logic [$clog2(MAX_COLUMNS)-1:0] wr_col,
   input  wire logic [COST_BITS-1:0]        wr_cost,
   output mca_pkg::status_type              status,
   output logic [$clog2(MAX_COLUMNS)-1:0]   emit_col
);
   import mca_pkg::*;
   localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CB = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int AB = RB + CB;

   logic signed [DUAL_BITS-1:0] u_ff [MAX_ROWS];
   logic signed [DUAL_BITS-1:0] v_ff [MAX_COLUMNS];
   logic [CB:0] rp_ff [MAX_ROWS];
   logic [RB:0] cp_ff [MAX_COLUMNS];
   logic [RB-1:0] pred_ff [MAX_COLUMNS];
   logic [RB-1:0] best_ff [MAX_COLUMNS];
   logic [MAX_ROWS-1:0] rvis_ff;
   logic [MAX_COLUMNS-1:0] cvis_ff;
   logic signed [DUAL_BITS-1:0] w_ff;
   logic w_inf_ff;
   logic [CB:0] right_ff;
   logic [RB-1:0] next_ff;
   logic [CB-1:0] scol_ff;
   logic [RB-1:0] srow_ff;
   logic signed [DUAL_BITS-1:0] red_best_ff;

   logic [AB-1:0] rd_addr;
   logic [COST_BITS-1:0] rd_data;
   logic signed [DUAL_BITS-1:0] red_cur;

   mca_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_ROWS * MAX_COLUMNS)) u_cost (
      .clock(clock), .wr_en(wr_en),
      .wr_addr(AB'(wr_row * MAX_COLUMNS + wr_col)),
      .wr_data(wr_cost),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // row read for issue: best_row of column, or next row on relax
   always_comb begin
      if (cmd.relax_issue) rd_addr = AB'(next_ff * MAX_COLUMNS + col_idx);
      else rd_addr = AB'(best_ff[col_idx] * MAX_COLUMNS + col_idx);
   end

   // reduced cost of the row read in the previous cycle
   always_comb begin
      red_cur = DUAL_BITS'($signed(rd_data)) + u_ff[srow_ff] + v_ff[scol_ff];
   end

   logic [RB-1:0] left_row;
   logic [CB:0] prev_col;
   assign left_row = pred_ff[right_ff[CB-1:0]];
   assign prev_col = rp_ff[left_row];

   always_ff @(posedge clock) begin
      if (cmd.min_issue || cmd.zero_issue || cmd.relax_issue || cmd.best_issue) begin
         scol_ff <= col_idx;
         srow_ff <= cmd.relax_issue ? next_ff : best_ff[col_idx];
      end
      if (cmd.clear_all) begin
         for (int i = 0; i < MAX_ROWS; i++) begin
            u_ff[i] <= '0;
            rp_ff[i] <= {1'b1, {CB{1'b0}}};
         end
         for (int j = 0; j < MAX_COLUMNS; j++) begin
            v_ff[j] <= '0;
            cp_ff[j] <= {1'b1, {RB{1'b0}}};
         end
      end
      if (cmd.phase_start) begin
         for (int j = 0; j < MAX_COLUMNS; j++) best_ff[j] <= start_row;
         cvis_ff <= '0;
         rvis_ff <= MAX_ROWS'(1) << start_row;
      end
      if (cmd.min_clear) w_inf_ff <= 1'b1;
      if (cmd.min_acc && !cvis_ff[scol_ff] && (w_inf_ff || red_cur < w_ff)) begin
         w_ff <= red_cur;
         w_inf_ff <= 1'b0;
      end
      if (cmd.apply_delta) begin
         for (int i = 0; i < MAX_ROWS; i++)
            if (rvis_ff[i] && RB'(i) <= n_last) u_ff[i] <= u_ff[i] - w_ff;
         for (int j = 0; j < MAX_COLUMNS; j++)
            if (cvis_ff[j] && CB'(j) <= m_last) v_ff[j] <= v_ff[j] + w_ff;
      end
      if (cmd.zero_clear) right_ff <= {1'b1, {CB{1'b0}}};
      if (cmd.zero_acc && !cvis_ff[scol_ff] && red_cur == '0)
         right_ff <= {1'b0, scol_ff};
      if (cmd.pick) begin
         pred_ff[right_ff[CB-1:0]] <= best_ff[right_ff[CB-1:0]];
         next_ff <= cp_ff[right_ff[CB-1:0]][RB-1:0];
         if (!cp_ff[right_ff[CB-1:0]][RB]) begin
            rvis_ff[cp_ff[right_ff[CB-1:0]][RB-1:0]] <= 1'b1;
            cvis_ff[right_ff[CB-1:0]] <= 1'b1;
         end
      end
      if (cmd.aug_step) begin
         cp_ff[right_ff[CB-1:0]] <= {1'b0, left_row};
         rp_ff[left_row] <= {1'b0, right_ff[CB-1:0]};
         right_ff <= prev_col;
      end
      // hold the reduced cost of the current best row while the next row is read
      if (cmd.best_capture) red_best_ff <= red_cur;
      if (cmd.relax_acc && red_cur < red_best_ff) best_ff[scol_ff] <= next_ff;
   end

   assign status.have_right = !right_ff[CB];
   assign status.right_free = cp_ff[right_ff[CB-1:0]][RB];
   assign status.aug_done = right_ff[CB];
   assign emit_col = rp_ff[row_idx][CB] ? '0 : rp_ff[row_idx][CB-1:0];
endmodule
`default_nettype wire

### rtl/mca_control.sv
`timescale 1ns / 1ps
`default_nettype none
module mca_control #(
   parameter int MAX_ROWS    = 16,
   parameter int MAX_COLUMNS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load_done,
   input  wire logic                 too_many_rows,
   input  wire logic [$clog2(MAX_ROWS)-1:0]    n_last,
   input  wire logic [$clog2(MAX_COLUMNS)-1:0] m_last,
   input  wire mca_pkg::status_type  status,
   input  wire logic                 rsp_ready,
   output mca_pkg::cmd_type          cmd,
   output logic [$clog2(MAX_ROWS)-1:0]    row_idx,
   output logic [$clog2(MAX_COLUMNS)-1:0] col_idx,
   output logic [$clog2(MAX_ROWS)-1:0]    start_row,
   output logic                      loading,
   output logic                      rsp_valid,
   output logic                      rsp_error,
   output logic                      rsp_last
);
   import mca_pkg::*;
   localparam int RB = $clog2(MAX_ROWS);
   localparam int CB = $clog2(MAX_COLUMNS);

   state_type state_ff, state_in;
   logic [RB-1:0] s_ff, s_in, r_ff, r_in;
   logic [CB-1:0] c_ff, c_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         s_ff <= '0;
         r_ff <= '0;
         c_ff <= '0;
      end else begin
         state_ff <= state_in;
         s_ff <= s_in;
         r_ff <= r_in;
         c_ff <= c_in;
      end
   end

   assign start_row = s_ff;
   assign row_idx = r_ff;
   assign col_idx = c_ff;
   assign loading = (state_ff == ST_LOAD);

   always_comb begin
      state_in = state_ff;
      s_in = s_ff;
      r_in = r_ff;
      c_in = c_ff;
      cmd = '0;
      rsp_valid = 1'b0;
      rsp_error = 1'b0;
      rsp_last = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (load_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = too_many_rows ? ST_ERROR : ST_INIT;
         end
         ST_ERROR: begin
            rsp_valid = 1'b1;
            rsp_error = 1'b1;
            rsp_last = 1'b1;
            if (rsp_ready) state_in = ST_LOAD;
         end
         ST_INIT: begin
            cmd.clear_all = 1'b1;
            s_in = '0;
            state_in = ST_PHASE;
         end
         ST_PHASE: begin
            cmd.phase_start = 1'b1;
            cmd.min_clear = 1'b1;
            c_in = '0;
            state_in = ST_MIN_REQ;
         end
         ST_MIN_REQ: begin
            cmd.min_issue = 1'b1;
            state_in = ST_MIN_ACC;
         end
         ST_MIN_ACC: begin
            cmd.min_acc = 1'b1;
            if (c_ff == m_last) begin
               state_in = ST_UPDATE;
            end else begin
               c_in = c_ff + 1'b1;
               state_in = ST_MIN_REQ;
            end
         end
         ST_UPDATE: begin
            cmd.apply_delta = 1'b1;
            cmd.zero_clear = 1'b1;
            c_in = '0;
            state_in = ST_ZERO_REQ;
         end
         ST_ZERO_REQ: begin
            cmd.zero_issue = 1'b1;
            state_in = ST_ZERO_ACC;
         end
         ST_ZERO_ACC: begin
            cmd.zero_acc = 1'b1;
            if (c_ff == m_last) begin
               state_in = ST_PICK;
            end else begin
               c_in = c_ff + 1'b1;
               state_in = ST_ZERO_REQ;
            end
         end
         ST_PICK: begin
            if (!status.have_right) begin
               state_in = ST_EMIT;
               r_in = '0;
            end else begin
               cmd.pick = 1'b1;
               c_in = '0;
               state_in = status.right_free ? ST_AUG : ST_RELAX_REQ;
            end
         end
         ST_AUG: begin
            if (status.aug_done) begin
               if (s_ff == n_last) begin
                  r_in = '0;
                  state_in = ST_EMIT;
               end else begin
                  s_in = s_ff + 1'b1;
                  state_in = ST_PHASE;
               end
            end else begin
               cmd.aug_step = 1'b1;
            end
         end
         ST_RELAX_REQ: begin
            cmd.best_issue = 1'b1;
            state_in = ST_RELAX_BEST;
         end
         ST_RELAX_BEST: begin
            cmd.best_capture = 1'b1;
            cmd.relax_issue = 1'b1;
            state_in = ST_RELAX_ACC;
         end
         ST_RELAX_ACC: begin
            cmd.relax_acc = 1'b1;
            if (c_ff == m_last) begin
               cmd.min_clear = 1'b1;
               c_in = '0;
               state_in = ST_MIN_REQ;
            end else begin
               c_in = c_ff + 1'b1;
               state_in = ST_RELAX_REQ;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last = (r_ff == n_last);
            if (rsp_ready) begin
               if (r_ff == n_last) state_in = ST_LOAD;
               else r_in = r_ff + 1'b1;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end
endmodule
`default_nettype wire

### rtl/min_cost_assignment.sv
`timescale 1ns / 1ps
`default_nettype none
// Minimum-cost assignment solver (shortest-augmenting-path Hungarian method).
// Write row_count and column_count, then stream the cost matrix row-major,
// one signed cost per item. After the final entry the block solves and emits
// one item per row (matched column, last on the final row), or one error item
// when rows exceed columns. Costs are accepted while the block is loading.
// Each Dijkstra step scans the columns for the minimum slack and the zero slack
// and, unless the picked column is free, once more for the relaxation (two cost
// reads a column); row s takes at most s+1 steps, and all scans share the single
// read port of the cost memory. Results then leave one per cycle while ready.
module min_cost_assignment
   import mca_pkg::*;
#(
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int COST_BITS   = DEF_COST_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write,
   input  wire logic [0:0] csr_index,
   input  wire logic [COUNT_BITS-1:0] csr_data,
   mca_req_if.sink   req,
   mca_rsp_if.source rsp
);
   localparam int RB = $clog2(MAX_ROWS);
   localparam int CB = $clog2(MAX_COLUMNS);
   localparam int PB = $clog2(MAX_ROWS * MAX_COLUMNS + 1);

   logic [COUNT_BITS-1:0] rows_ff, cols_ff;
   logic [RB-1:0] wr_row_ff;
   logic [CB-1:0] wr_col_ff;
   logic [PB-1:0] pos_ff;
   logic [PB-1:0] total;
   cmd_type cmd;
   status_type status;
   logic [RB-1:0] row_idx, start_row, n_last;
   logic [CB-1:0] col_idx, m_last, emit_col;
   logic loading, load_done, accept, rsp_error, rsp_last;

   function automatic logic [COUNT_BITS-1:0] clamp(input logic [COUNT_BITS-1:0] v,
                                                  input int maxv);
      if (v == '0) return COUNT_BITS'(1);
      if (int'(v) > maxv) return COUNT_BITS'(maxv);
      return v;
   endfunction

   assign total = PB'(rows_ff) * PB'(cols_ff);
   assign n_last = RB'(rows_ff - 1'b1);
   assign m_last = CB'(cols_ff - 1'b1);
   assign req.ready = loading;
   assign accept = req.valid && req.ready;
   assign load_done = accept && (pos_ff + 1'b1 == total);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= clamp(COUNT_BITS'(16), MAX_ROWS);
         cols_ff <= clamp(COUNT_BITS'(16), MAX_COLUMNS);
         pos_ff <= '0;
         wr_row_ff <= '0;
         wr_col_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_ROW_COUNT) rows_ff <= clamp(csr_data, MAX_ROWS);
         else cols_ff <= clamp(csr_data, MAX_COLUMNS);
         pos_ff <= '0;
         wr_row_ff <= '0;
         wr_col_ff <= '0;
      end else if (accept) begin
         if (load_done) begin
            pos_ff <= '0;
            wr_row_ff <= '0;
            wr_col_ff <= '0;
         end else begin
            pos_ff <= pos_ff + 1'b1;
            if (wr_col_ff == m_last) begin
               wr_col_ff <= '0;
               wr_row_ff <= wr_row_ff + 1'b1;
            end else begin
               wr_col_ff <= wr_col_ff + 1'b1;
            end
         end
      end
   end

   mca_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS), .COST_BITS(COST_BITS))
   u_dp (
      .clock(clock), .cmd(cmd), .row_idx(row_idx), .col_idx(col_idx),
      .start_row(start_row), .n_last(n_last), .m_last(m_last),
      .wr_en(accept), .wr_row(wr_row_ff), .wr_col(wr_col_ff), .wr_cost(req.cost),
      .status(status), .emit_col(emit_col)
   );

   mca_control #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_ctl (
      .clock(clock), .reset(reset), .load_done(load_done),
      .too_many_rows(rows_ff > cols_ff), .n_last(n_last), .m_last(m_last),
      .status(status), .rsp_ready(rsp.ready), .cmd(cmd), .row_idx(row_idx),
      .col_idx(col_idx), .start_row(start_row), .loading(loading),
      .rsp_valid(rsp.valid), .rsp_error(rsp_error), .rsp_last(rsp_last)
   );

   assign rsp.row = rsp_error ? 4'd0 : FIELD_BITS'(row_idx);
   assign rsp.column = rsp_error ? 4'd0 : FIELD_BITS'(emit_col);
   assign rsp.last = rsp_last;
   assign rsp.error = rsp_error;
endmodule
`default_nettype wire
